[src/hta_pkg.sv]
// Shared types and constants for the handle table allocator.
`default_nettype none
package hta_pkg;

  localparam int MAX_HANDLES      = 1024;
  localparam int INITIAL_CAPACITY = 2;
  localparam int HANDLE_W         = $clog2(MAX_HANDLES);
  localparam int LINK_W           = HANDLE_W + 1;
  localparam int KIND_W           = 3;

  localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_HANDLES);
  localparam logic [LINK_W-1:0] HALF_MAX = LINK_W'(MAX_HANDLES / 2);
  localparam logic [LINK_W-1:0] INIT_CAP = LINK_W'(INITIAL_CAPACITY);

  localparam logic [KIND_W-1:0] KIND_FREE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MIN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MAX  = 3'd5;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_IN_USE = 2'd1,
    ST_FULL       = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_WALK,
    S_IDLE,
    S_LOOKUP
  } state_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [HANDLE_W-1:0] handle_in;
    logic [KIND_W-1:0]   entry_kind;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [1:0]          status;
    logic                in_use;
    logic [KIND_W-1:0]   removed_kind;
  } rsp_t;

  // Command to the table walker
  typedef struct packed {
    logic                start;
    logic [HANDLE_W-1:0] base;
    logic [HANDLE_W-1:0] last;
    logic                top;
    logic [KIND_W-1:0]   kind;
  } walk_cmd_t;

  // One write into the link and tag memories
  typedef struct packed {
    logic                en_link;
    logic                en_tag;
    logic [HANDLE_W-1:0] addr;
    logic [LINK_W-1:0]   link;
    logic [KIND_W-1:0]   tag;
  } mem_wr_t;

endpackage
`default_nettype wire

[src/hta_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/hta_walk.sv]
// Table walker: writes a run of fresh entries, one per cycle, linked downward.
`default_nettype none
module hta_walk (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hta_pkg::walk_cmd_t cmd,
  output logic                   busy,
  output hta_pkg::mem_wr_t       wr
);

  logic                         active;
  logic [hta_pkg::HANDLE_W-1:0] addr;
  logic [hta_pkg::HANDLE_W-1:0] base;
  logic [hta_pkg::HANDLE_W-1:0] last;
  logic                         top;
  logic [hta_pkg::KIND_W-1:0]   kind;

  // Walk control; after reset it lays out the initial entries
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      addr   <= '0;
      base   <= '0;
      last   <= hta_pkg::HANDLE_W'(hta_pkg::INITIAL_CAPACITY - 1);
      top    <= 1'b0;
      kind   <= hta_pkg::KIND_FREE;
    end else if (cmd.start) begin
      active <= 1'b1;
      addr   <= cmd.base;
      base   <= cmd.base;
      last   <= cmd.last;
      top    <= cmd.top;
      kind   <= cmd.kind;
    end else if (active) begin
      addr <= addr + 1'b1;
      if (addr == last) begin
        active <= 1'b0;
      end
    end
  end

  // First entry ends the list, each later one links to its predecessor;
  // the top entry optionally goes straight into use
  always_comb begin
    busy       = active;
    wr.en_link = active;
    wr.en_tag  = active;
    wr.addr    = addr;
    wr.link    = (addr == base) ? hta_pkg::LIST_END
                                : {1'b0, addr - 1'b1};
    wr.tag     = (top && addr == last) ? kind : hta_pkg::KIND_FREE;
  end

endmodule
`default_nettype wire

[src/handle_table_allocator_core.sv]
// Top level of the handle table allocator: control, free-list head and memories.
//
// For each request, the cycle it is accepted issues the read of the
// addressed entry (free-list head for allocate, handle_in otherwise) from the
// link and tag memories, and the next cycle modifies, writes back and loads the
// response register. An allocate that finds the free list empty doubles the
// capacity; its response is ready right away, but the walker then writes the
// new entries one per cycle, and the next request waits until the walker is
// done. After reset the walker lays out the initial entries, which holds off
// requests until it is done. The contents of entries at or above the capacity
// are never used before the walker writes them, so the memories need no full
// clearing pass. A write always lands before the next read is issued.
`default_nettype none
module handle_table_allocator_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire hta_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output hta_pkg::rsp_t      rsp
);

  hta_pkg::state_e state, state_next;

  logic [hta_pkg::LINK_W-1:0] free_head, free_head_next;
  logic [hta_pkg::LINK_W-1:0] capacity, capacity_next;
  hta_pkg::req_t              item;
  hta_pkg::rsp_t              rsp_next;
  logic                       rsp_load;

  logic                         accept;
  logic [hta_pkg::HANDLE_W-1:0] rd_addr;
  logic [hta_pkg::LINK_W-1:0]   link_rd;
  logic [hta_pkg::KIND_W-1:0]   tag_rd;

  hta_pkg::walk_cmd_t walk_cmd;
  hta_pkg::mem_wr_t   walk_wr;
  hta_pkg::mem_wr_t   look_wr;
  hta_pkg::mem_wr_t   wr;
  logic               walk_busy;

  logic                       busy_entry;
  logic [hta_pkg::LINK_W-1:0] cap2;

  // Memories
  hta_ram #(.WIDTH(hta_pkg::LINK_W), .DEPTH(hta_pkg::MAX_HANDLES)) u_link_ram (
    .clk   (clk),
    .we    (wr.en_link),
    .waddr (wr.addr),
    .wdata (wr.link),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  hta_ram #(.WIDTH(hta_pkg::KIND_W), .DEPTH(hta_pkg::MAX_HANDLES)) u_tag_ram (
    .clk   (clk),
    .we    (wr.en_tag),
    .waddr (wr.addr),
    .wdata (wr.tag),
    .raddr (rd_addr),
    .rdata (tag_rd)
  );

  hta_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .cmd  (walk_cmd),
    .busy (walk_busy),
    .wr   (walk_wr)
  );

  // Handshake and read address
  always_comb begin
    req_ready = (state == hta_pkg::S_IDLE) && (!rsp_valid || rsp_ready);
    accept    = req_valid && req_ready;
    rd_addr   = (hta_pkg::op_e'(req.op) == hta_pkg::OP_ALLOC)
                ? free_head[hta_pkg::HANDLE_W-1:0] : req.handle_in;
    wr        = walk_busy ? walk_wr : look_wr;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      hta_pkg::S_WALK: begin
        if (!walk_busy) state_next = hta_pkg::S_IDLE;
      end
      hta_pkg::S_IDLE: begin
        if (accept) state_next = hta_pkg::S_LOOKUP;
      end
      hta_pkg::S_LOOKUP: begin
        state_next = walk_cmd.start ? hta_pkg::S_WALK : hta_pkg::S_IDLE;
      end
      default: state_next = hta_pkg::S_IDLE;
    endcase
  end

  // Lookup: decide the response and the write-back from the entry just read
  always_comb begin
    busy_entry     = ({1'b0, item.handle_in} < capacity) &&
                     (tag_rd != hta_pkg::KIND_FREE);
    cap2           = capacity << 1;
    free_head_next = free_head;
    capacity_next  = capacity;
    rsp_load       = 1'b0;
    rsp_next.handle_out   = item.handle_in;
    rsp_next.status       = hta_pkg::ST_OK;
    rsp_next.in_use       = 1'b0;
    rsp_next.removed_kind = hta_pkg::KIND_FREE;
    look_wr.en_link = 1'b0;
    look_wr.en_tag  = 1'b0;
    look_wr.addr    = item.handle_in;
    look_wr.link    = free_head;
    look_wr.tag     = hta_pkg::KIND_FREE;
    walk_cmd.start  = 1'b0;
    walk_cmd.base   = capacity[hta_pkg::HANDLE_W-1:0];
    walk_cmd.last   = hta_pkg::HANDLE_W'(cap2 - 1'b1);
    walk_cmd.top    = 1'b1;
    walk_cmd.kind   = item.entry_kind;

    if (state == hta_pkg::S_LOOKUP) begin
      rsp_load = 1'b1;
      unique case (hta_pkg::op_e'(item.op))
        hta_pkg::OP_ALLOC: begin
          priority if (item.entry_kind < hta_pkg::KIND_MIN ||
                       item.entry_kind > hta_pkg::KIND_MAX) begin
            rsp_next.status = hta_pkg::ST_NOT_IN_USE;
          end else if (free_head != hta_pkg::LIST_END) begin
            // pop the free head
            free_head_next      = link_rd;
            look_wr.en_tag      = 1'b1;
            look_wr.addr        = free_head[hta_pkg::HANDLE_W-1:0];
            look_wr.tag         = item.entry_kind;
            rsp_next.handle_out = free_head[hta_pkg::HANDLE_W-1:0];
          end else if (capacity > hta_pkg::HALF_MAX) begin
            rsp_next.status = hta_pkg::ST_FULL;
          end else begin
            // grow: walker fills the new half, top entry is granted
            walk_cmd.start      = 1'b1;
            capacity_next       = cap2;
            free_head_next      = (capacity >= hta_pkg::LINK_W'(2))
                                  ? cap2 - hta_pkg::LINK_W'(2) : hta_pkg::LIST_END;
            rsp_next.handle_out = hta_pkg::HANDLE_W'(cap2 - 1'b1);
          end
        end
        hta_pkg::OP_REMOVE: begin
          if (busy_entry) begin
            rsp_next.removed_kind = tag_rd;
            look_wr.en_link       = 1'b1;
            look_wr.en_tag        = 1'b1;
            free_head_next        = {1'b0, item.handle_in};
          end else begin
            rsp_next.status = hta_pkg::ST_NOT_IN_USE;
          end
        end
        hta_pkg::OP_CHECK: begin
          rsp_next.in_use = busy_entry;
        end
        hta_pkg::OP_UNUSED: begin
          rsp_next.in_use = 1'b0;
        end
        default: rsp_next.in_use = 1'b0;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hta_pkg::S_WALK;
      free_head <= hta_pkg::INIT_CAP - 1'b1;
      capacity  <= hta_pkg::INIT_CAP;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      capacity  <= capacity_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

[tb/hta_checker.sv]
// Response checker for the handle table allocator: predicts every response item and compares it.
module hta_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  hta_pkg::req_t          req,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  hta_pkg::rsp_t          rsp,
  output int                     fail_count,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the handle table
  logic [hta_pkg::LINK_W-1:0] next_free [hta_pkg::MAX_HANDLES];
  logic [hta_pkg::KIND_W-1:0] kind_of   [hta_pkg::MAX_HANDLES];
  logic [hta_pkg::LINK_W-1:0] free_top;
  logic [hta_pkg::LINK_W-1:0] table_cap;

  // Responses predicted but not yet seen, oldest first
  hta_pkg::rsp_t due_rsp [$];
  hta_pkg::rsp_t want;

  // Push a handle on the free list
  task automatic release_handle(input logic [hta_pkg::HANDLE_W-1:0] h);
    next_free[h] = free_top;
    free_top     = {1'b0, h};
  endtask

  // Table contents right after reset
  task automatic reset_table();
    logic [hta_pkg::LINK_W-1:0] h;
    for (h = '0; h < hta_pkg::LIST_END; h++) begin
      kind_of[h[hta_pkg::HANDLE_W-1:0]]   = hta_pkg::KIND_FREE;
      next_free[h[hta_pkg::HANDLE_W-1:0]] = hta_pkg::LIST_END;
    end
    table_cap = hta_pkg::INIT_CAP;
    free_top  = hta_pkg::LIST_END;
    for (h = '0; h < hta_pkg::INIT_CAP; h++) release_handle(h[hta_pkg::HANDLE_W-1:0]);
  endtask

  function automatic logic holds_entry(input logic [hta_pkg::HANDLE_W-1:0] h);
    return ({1'b0, h} < table_cap) && (kind_of[h] != hta_pkg::KIND_FREE);
  endfunction

  // Apply one request to the shadow table and work out its response
  task automatic compute_response(input hta_pkg::req_t r, output hta_pkg::rsp_t e);
    logic [hta_pkg::HANDLE_W-1:0] h;
    logic [hta_pkg::LINK_W-1:0]   old_cap;
    logic [hta_pkg::LINK_W-1:0]   top_h;
    logic [hta_pkg::LINK_W-1:0]   i;
    e.handle_out   = r.handle_in;
    e.status       = hta_pkg::ST_OK;
    e.in_use       = 1'b0;
    e.removed_kind = hta_pkg::KIND_FREE;
    case (r.op)
      hta_pkg::OP_ALLOC: begin
        if (r.entry_kind < hta_pkg::KIND_MIN || r.entry_kind > hta_pkg::KIND_MAX) begin
          e.status = hta_pkg::ST_NOT_IN_USE;
        end else if (free_top != hta_pkg::LIST_END) begin
          h            = free_top[hta_pkg::HANDLE_W-1:0];
          free_top     = next_free[h];
          kind_of[h]   = r.entry_kind;
          e.handle_out = h;
        end else if (table_cap > hta_pkg::HALF_MAX) begin
          e.status = hta_pkg::ST_FULL;
        end else begin
          // Doubling: new handles go on the list in rising order, the top one is granted
          old_cap   = table_cap;
          table_cap = old_cap << 1;
          for (i = old_cap; i + 1'b1 < table_cap; i++) begin
            kind_of[i[hta_pkg::HANDLE_W-1:0]] = hta_pkg::KIND_FREE;
            release_handle(i[hta_pkg::HANDLE_W-1:0]);
          end
          top_h        = table_cap - 1'b1;
          h            = top_h[hta_pkg::HANDLE_W-1:0];
          kind_of[h]   = r.entry_kind;
          e.handle_out = h;
        end
      end
      hta_pkg::OP_REMOVE: begin
        if (holds_entry(r.handle_in)) begin
          e.removed_kind       = kind_of[r.handle_in];
          kind_of[r.handle_in] = hta_pkg::KIND_FREE;
          release_handle(r.handle_in);
        end else begin
          e.status = hta_pkg::ST_NOT_IN_USE;
        end
      end
      hta_pkg::OP_CHECK: begin
        e.in_use = holds_entry(r.handle_in);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Compare responses first: a request accepted on this edge cannot answer on it
  always @(posedge clk) begin
    if (rst) begin
      reset_table();
      due_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          $error("response item with no request outstanding");
          fail_count++;
        end else begin
          want = due_rsp.pop_front();
          check_field("handle_out", 16'(want.handle_out), 16'(rsp.handle_out));
          check_field("status", 16'(want.status), 16'(rsp.status));
          check_field("in_use", 16'(want.in_use), 16'(rsp.in_use));
          check_field("removed_kind", 16'(want.removed_kind), 16'(rsp.removed_kind));
        end
      end
      if (req_valid && req_ready) begin
        compute_response(req, want);
        due_rsp.push_back(want);
      end
    end
    outstanding = due_rsp.size();
  end

endmodule

[tb/testbench.sv]
// Top of the handle table allocator testbench: clock, reset, request stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 2000;

  // Entry kinds
  localparam logic [hta_pkg::KIND_W-1:0] KIND_PORT        = 3'd1;
  localparam logic [hta_pkg::KIND_W-1:0] KIND_REMOTE_PORT = 3'd2;
  localparam logic [hta_pkg::KIND_W-1:0] KIND_THREAD      = 3'd3;
  localparam logic [hta_pkg::KIND_W-1:0] KIND_MEMORY      = 3'd4;
  localparam logic [hta_pkg::KIND_W-1:0] KIND_EVENT_QUEUE = 3'd5;
  localparam logic [hta_pkg::KIND_W-1:0] KIND_BAD_LO      = 3'd6;
  localparam logic [hta_pkg::KIND_W-1:0] KIND_BAD_HI      = 3'd7;

  // Handles used by the directed items
  localparam logic [hta_pkg::HANDLE_W-1:0] H_ZERO  = '0;
  localparam logic [hta_pkg::HANDLE_W-1:0] H_THREE = hta_pkg::HANDLE_W'(3);
  localparam logic [hta_pkg::HANDLE_W-1:0] H_SEVEN = hta_pkg::HANDLE_W'(7);
  localparam logic [hta_pkg::HANDLE_W-1:0] H_TOP   =
    hta_pkg::HANDLE_W'(hta_pkg::MAX_HANDLES - 1);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  hta_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  hta_pkg::rsp_t rsp;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int burst_left  = 0;
  int sent        = 0;
  int granted     = 0;
  bit calm        = 1'b0;

  handle_table_allocator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  hta_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Response side back-pressure: each window picks its own pattern
  initial begin
    int mode;
    int span;
    int phase;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: rsp_ready = 1'b1;
          1: rsp_ready = 1'($urandom_range(0, 1));
          2: begin
            phase++;
            rsp_ready = (phase % 4 == 0);
          end
          default: rsp_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic hta_pkg::req_t make_req(input logic [1:0] op,
                                             input logic [hta_pkg::HANDLE_W-1:0] h,
                                             input logic [hta_pkg::KIND_W-1:0] k);
    hta_pkg::req_t r;
    r.op         = op;
    r.handle_in  = h;
    r.entry_kind = k;
    return r;
  endfunction

  // Random field values
  function automatic logic [hta_pkg::HANDLE_W-1:0] any_handle();
    return hta_pkg::HANDLE_W'($urandom);
  endfunction

  function automatic logic [hta_pkg::KIND_W-1:0] any_kind();
    return hta_pkg::KIND_W'($urandom);
  endfunction

  function automatic logic [hta_pkg::KIND_W-1:0] good_kind();
    return hta_pkg::KIND_W'($urandom_range(hta_pkg::KIND_MIN, hta_pkg::KIND_MAX));
  endfunction

  // Rough capacity from the grants issued so far
  function automatic int cap_guess();
    int c;
    c = hta_pkg::INITIAL_CAPACITY;
    while (c < granted && c < hta_pkg::MAX_HANDLES) c = c * 2;
    return c;
  endfunction

  function automatic logic [hta_pkg::KIND_W-1:0] bad_kind();
    case ($urandom_range(0, 2))
      0:       return hta_pkg::KIND_FREE;
      1:       return KIND_BAD_LO;
      default: return KIND_BAD_HI;
    endcase
  endfunction

  // Send one item; bursts of random length with random gaps, and calm stretches with none
  task automatic push_item(input hta_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) calm = !calm;
      gap        = calm ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        req_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req       = r;
    req_valid = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  initial begin
    int pick;
    int n;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: bad removes, bad kinds, early doublings, LIFO reuse, unused op
    push_item(make_req(hta_pkg::OP_CHECK,  H_ZERO, hta_pkg::KIND_FREE));
    push_item(make_req(hta_pkg::OP_CHECK,  H_TOP, KIND_BAD_HI));
    push_item(make_req(hta_pkg::OP_REMOVE, H_ZERO, hta_pkg::KIND_FREE));
    push_item(make_req(hta_pkg::OP_REMOVE, H_TOP, KIND_BAD_HI));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_TOP, hta_pkg::KIND_FREE));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_TOP, KIND_BAD_LO));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_TOP, KIND_BAD_HI));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_ZERO, KIND_PORT));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_ZERO, KIND_EVENT_QUEUE));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_TOP, KIND_REMOTE_PORT));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_ZERO, KIND_THREAD));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_ZERO, KIND_MEMORY));
    push_item(make_req(hta_pkg::OP_CHECK,  H_SEVEN, hta_pkg::KIND_FREE));
    push_item(make_req(hta_pkg::OP_CHECK,  H_THREE, KIND_BAD_HI));
    push_item(make_req(hta_pkg::OP_REMOVE, H_SEVEN, hta_pkg::KIND_FREE));
    push_item(make_req(hta_pkg::OP_REMOVE, H_SEVEN, hta_pkg::KIND_FREE));
    push_item(make_req(hta_pkg::OP_CHECK,  H_SEVEN, hta_pkg::KIND_FREE));
    push_item(make_req(hta_pkg::OP_UNUSED, H_TOP, KIND_BAD_HI));
    push_item(make_req(hta_pkg::OP_UNUSED, H_ZERO, hta_pkg::KIND_FREE));
    push_item(make_req(hta_pkg::OP_REMOVE, H_ZERO, KIND_BAD_HI));
    push_item(make_req(hta_pkg::OP_ALLOC,  H_TOP, KIND_PORT));
    push_item(make_req(hta_pkg::OP_CHECK,  H_TOP, KIND_BAD_HI));
    granted = 4;

    // Fill: grow through every doubling up to the full table, no removes
    while (granted < hta_pkg::MAX_HANDLES + 12) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        push_item(make_req(hta_pkg::OP_ALLOC, any_handle(), good_kind()));
        granted++;
      end else if (pick < 88) begin
        push_item(make_req(hta_pkg::OP_CHECK,
                           hta_pkg::HANDLE_W'($urandom_range(0, cap_guess() - 1)),
                           any_kind()));
      end else if (pick < 94) begin
        push_item(make_req(hta_pkg::OP_ALLOC, any_handle(), bad_kind()));
      end else begin
        push_item(make_req($urandom_range(0, 1) ? hta_pkg::OP_CHECK : hta_pkg::OP_UNUSED,
                           any_handle(), any_kind()));
      end
    end

    // Churn: bursts of removes and reallocations on the full table, plus noise
    while (sent < RANDOM_ITEMS + 25) begin
      pick = $urandom_range(0, 9);
      n    = $urandom_range(1, 40);
      repeat (n) begin
        if (pick < 4) begin
          push_item(make_req(hta_pkg::OP_REMOVE, any_handle(), any_kind()));
        end else if (pick < 8) begin
          if ($urandom_range(0, 15) == 0) begin
            push_item(make_req(hta_pkg::OP_ALLOC, any_handle(), bad_kind()));
          end else begin
            push_item(make_req(hta_pkg::OP_ALLOC, any_handle(), good_kind()));
          end
        end else if (pick == 8) begin
          push_item(make_req(hta_pkg::OP_CHECK, any_handle(), any_kind()));
        end else begin
          push_item(make_req(2'($urandom_range(0, 3)), any_handle(), any_kind()));
        end
      end
    end

    @(negedge clk);
    req_valid = 1'b0;

    // Drain, then let a possible table walk finish
    while (outstanding != 0) @(posedge clk);
    repeat (hta_pkg::MAX_HANDLES / 2 + 8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
